/* rtl/elsc_pkg.sv */
package elsc_pkg;

    localparam int OP_W    = 2;
    localparam int FLOOR_W = 5;
    localparam int CMD_W   = 2;

    localparam int DEF_FLOORS      = 16;
    localparam int DEF_START_LEVEL = 1;

    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_DONE    = 2'd1;
    localparam logic [OP_W-1:0] OP_SETTLE  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_STAND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DOWN  = 2'd3;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] PH_FREE    = 2'd0;
    localparam logic [1:0] PH_SOLVING = 2'd1;
    localparam logic [1:0] PH_WAITING = 2'd2;
    localparam logic [1:0] PH_READY   = 2'd3;

endpackage

/* rtl/elevator_scan_controller.sv */
// Single-car SCAN elevator controller. Each beat on the item channel is a floor
// request, a travel/door wait done event or a settle event; a decision gives one
// beat on the result channel (command, current floor, target floor), other events
// give none. Throughput is one item per cycle unless result_stall holds a result;
// an item passes the input register, then the decision and state update into the
// result register. The clock period is set by the decision path: a lowest/highest
// pending-floor search over FLOORS request bits, done combinationally so that the
// next item sees the new state. Requests for floor 0 or above FLOORS are dropped.
module elevator_scan_controller
#(
    parameter int FLOORS      = elsc_pkg::DEF_FLOORS,
    parameter int START_LEVEL = elsc_pkg::DEF_START_LEVEL
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [elsc_pkg::OP_W-1:0]     operation,
    input  logic [elsc_pkg::FLOOR_W-1:0]  floor,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [elsc_pkg::CMD_W-1:0]    command,
    output logic [elsc_pkg::FLOOR_W-1:0]  current_floor,
    output logic [elsc_pkg::FLOOR_W-1:0]  destination
);
    import elsc_pkg::*;

    localparam int FW    = $clog2(FLOORS);
    localparam int SUM_W = (FW + 1 > FLOOR_W) ? FW + 1 : FLOOR_W;
    localparam int START_IDX = (START_LEVEL > FLOORS) ? FLOORS - 1 : START_LEVEL - 1;
    localparam logic [FW-1:0] CAR_HOME = FW'(START_IDX);

    // input register
    logic                in_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [FLOOR_W-1:0]  floor_reg;

    // controller state
    logic [FLOORS-1:0]   bits_reg, bits_next;
    logic [FW-1:0]       car_reg, car_next;
    logic [FW-1:0]       goal_reg, goal_next;
    logic [1:0]          dir_reg, dir_next;
    logic [1:0]          phase_reg, phase_next;

    // result register
    logic                result_valid_reg;
    logic [CMD_W-1:0]    command_reg, command_next;
    logic [FLOOR_W-1:0]  current_reg, current_next;
    logic [FLOOR_W-1:0]  target_reg, target_next;

    logic                advance;
    logic                produce;

    // decision datapath
    logic                floor_ok;
    logic [FLOORS-1:0]   set_mask;
    logic [FLOORS-1:0]   bits_eff;
    logic [FW-1:0]       car_eff;
    logic                do_decide;
    logic [FLOORS-1:0]   up_vec, dn_vec, dn_rev, up_low, dn_low;
    logic                up_found, dn_found;
    logic [FW-1:0]       up_idx, dn_rev_idx, dn_idx;
    logic [FW-1:0]       goal_dec;
    logic [1:0]          dir_dec;
    logic [SUM_W-1:0]    car_sum, goal_sum;

    // the input register only loads when the pipe advances
    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = !advance;

    assign floor_ok = (floor_reg != '0) && (int'(floor_reg) <= FLOORS);
    assign set_mask = {{(FLOORS-1){1'b0}}, 1'b1} << (floor_reg - FLOOR_W'(1));

    always_comb
    begin
        bits_eff  = bits_reg;
        car_eff   = car_reg;
        do_decide = 1'b0;
        if (in_valid_reg)
        begin
            unique case (op_reg)
                OP_REQUEST:
                begin
                    if (floor_ok)
                    begin
                        bits_eff  = bits_reg | set_mask;
                        do_decide = (phase_reg == PH_FREE) || (phase_reg == PH_READY);
                    end
                end
                OP_DONE:
                begin
                    if (phase_reg == PH_WAITING)
                    begin
                        do_decide = 1'b1;
                        if (dir_reg == DIR_UP && int'(car_reg) + 1 < FLOORS)
                            car_eff = car_reg + FW'(1);
                        else if (dir_reg == DIR_DOWN && car_reg != '0)
                            car_eff = car_reg - FW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // pending floors at or above the car, and at or below it
    always_comb
    begin
        up_vec = bits_eff & ({FLOORS{1'b1}} << car_eff);
        dn_vec = bits_eff & ~(({FLOORS{1'b1}} << car_eff) << 1);
        for (int i = 0; i < FLOORS; i++)
            dn_rev[i] = dn_vec[FLOORS-1-i];
        up_low   = up_vec & (~up_vec + FLOORS'(1));
        dn_low   = dn_rev & (~dn_rev + FLOORS'(1));
        up_found = |up_vec;
        dn_found = |dn_vec;
        up_idx     = '0;
        dn_rev_idx = '0;
        for (int i = 0; i < FLOORS; i++)
        begin
            up_idx     = up_idx     | (up_low[i] ? FW'(i) : FW'(0));
            dn_rev_idx = dn_rev_idx | (dn_low[i] ? FW'(i) : FW'(0));
        end
        dn_idx = FW'(FLOORS - 1) - dn_rev_idx;
    end

    always_comb
    begin
        goal_dec = goal_reg;
        if (dir_reg != DIR_DOWN)
        begin
            if (up_found)
                goal_dec = up_idx;
            else if (dn_found)
                goal_dec = dn_idx;
        end
        else
        begin
            if (dn_found)
                goal_dec = dn_idx;
            else if (up_found)
                goal_dec = up_idx;
        end
        priority if (car_eff == goal_dec)
            dir_dec = DIR_NONE;
        else if (car_eff < goal_dec)
            dir_dec = DIR_UP;
        else
            dir_dec = DIR_DOWN;
    end

    assign car_sum  = SUM_W'(car_eff) + SUM_W'(1);
    assign goal_sum = SUM_W'(goal_dec) + SUM_W'(1);

    always_comb
    begin
        bits_next    = bits_eff;
        car_next     = car_eff;
        goal_next    = goal_reg;
        dir_next     = dir_reg;
        phase_next   = phase_reg;
        produce      = do_decide;
        command_next = CMD_STAND;
        current_next = car_sum[FLOOR_W-1:0];
        target_next  = goal_sum[FLOOR_W-1:0];
        if (do_decide)
        begin
            goal_next  = goal_dec;
            dir_next   = dir_dec;
            phase_next = PH_WAITING;
            priority if (bits_eff == '0)
                command_next = CMD_STAND;
            else if (dir_dec == DIR_NONE)
            begin
                command_next = CMD_STOP;
                bits_next    = bits_eff & ~({{(FLOORS-1){1'b0}}, 1'b1} << car_eff);
            end
            else if (dir_dec == DIR_UP)
                command_next = CMD_UP;
            else
                command_next = CMD_DOWN;
        end
        else if (in_valid_reg && op_reg == OP_SETTLE && phase_reg == PH_WAITING)
            phase_next = PH_FREE;
        else if (phase_reg == PH_SOLVING)
            phase_next = PH_WAITING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            bits_reg         <= '0;
            car_reg          <= CAR_HOME;
            goal_reg         <= '0;
            dir_reg          <= DIR_NONE;
            phase_reg        <= PH_FREE;
        end
        else if (advance)
        begin
            in_valid_reg     <= item_valid;
            result_valid_reg <= produce;
            if (in_valid_reg)
            begin
                bits_reg  <= bits_next;
                car_reg   <= car_next;
                goal_reg  <= goal_next;
                dir_reg   <= dir_next;
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg    <= operation;
            floor_reg <= floor;
            if (produce)
            begin
                command_reg <= command_next;
                current_reg <= current_next;
                target_reg  <= target_next;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign command       = command_reg;
    assign current_floor = current_reg;
    assign destination   = target_reg;

endmodule
